[rtl/tscc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscc_pkg: shared types and constants
// Boundary-term and result types, widths and the scaled fit matrix.
// ----------------------------------------------------------------------------
package tscc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int NUM_TERMS = 6;
    localparam int NUM_COEF  = 12;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 48;
    localparam int BASE_W    = 96;
    localparam int WGT_W     = 18;
    localparam int SUM_W     = 120;

    localparam int DEN       = 1944;
    localparam int DIV_ODD   = 243;
    localparam int DIV_SHIFT = 3;
    localparam int SAT_EXP   = 47;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_COEF - 1);
    localparam logic [IDX_W-1:0] IDX_ACC  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_VEL  = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_POS  = IDX_W'(3);

    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DEPTH   = 16;
    localparam int OUT_LVL_W   = $clog2(OUT_DEPTH + 1);

    typedef logic signed [BASE_W-1:0] base_t;

    typedef struct packed {
        logic [NUM_TERMS-1:0][BASE_W-1:0] term;
    } bases_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             last;
    } out_item_t;

    // 108 * fit matrix, columns for start p, v, a and end p, v, a
    localparam logic signed [11:0] MAT108 [9][NUM_TERMS] = '{
        '{ 12'sd486,   12'sd162,  12'sd18,   12'sd486,   -12'sd162,  12'sd18  },
        '{ -12'sd972,  -12'sd162, 12'sd45,   -12'sd972,  12'sd486,   -12'sd63 },
        '{ 12'sd1458,  12'sd324,  -12'sd81,  12'sd1458,  -12'sd648,  12'sd81  },
        '{ -12'sd486,  -12'sd216, 12'sd45,   -12'sd486,  12'sd216,   -12'sd27 },
        '{ -12'sd54,   12'sd48,   -12'sd7,   12'sd54,    -12'sd24,   12'sd3   },
        '{ 12'sd486,   12'sd0,    -12'sd9,   12'sd486,   -12'sd324,  12'sd99  },
        '{ -12'sd1458, 12'sd0,    12'sd27,   -12'sd1458, 12'sd972,   -12'sd243},
        '{ 12'sd1458,  12'sd0,    -12'sd27,  12'sd1458,  -12'sd864,  12'sd189 },
        '{ -12'sd486,  12'sd0,    12'sd9,    -12'sd378,  12'sd216,   -12'sd45 }
    };

    // integer weight of boundary term j in coefficient k, over DEN
    function automatic logic signed [WGT_W-1:0] coef_weight(
        input logic [IDX_W-1:0] k,
        input logic [2:0]       j
    );
        logic [3:0]              row;
        logic signed [WGT_W-1:0] m0, m1, m2, mj, w;
        row = (k <= IDX_POS || k > LAST_IDX) ? 4'd0 : 4'(k - IDX_POS);
        m0  = WGT_W'(MAT108[row][0]);
        m1  = WGT_W'(MAT108[row][1]);
        m2  = WGT_W'(MAT108[row][2]);
        mj  = (j > 3'd2 && j < 3'd6) ? WGT_W'(MAT108[row][j]) : '0;
        w   = '0;
        if (k == IDX_ACC) begin
            w = (j == 3'd2) ? WGT_W'(DEN / 2) : '0;
        end else if (k == IDX_VEL) begin
            w = (j == 3'd1) ? WGT_W'(DEN) : '0;
        end else if (k == IDX_POS) begin
            w = (j == 3'd0) ? WGT_W'(DEN) : '0;
        end else begin
            unique case (j)
                3'd0:    w = -(m0 * 18);
                3'd1:    w = -(m0 * 6) - (m1 * 18);
                3'd2:    w = -m0 - (m1 * 6) - (m2 * 18);
                default: w = mj * 18;
            endcase
        end
        return w;
    endfunction

endpackage

[rtl/tscc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscc_fifo: small synchronous queue
// Register-based FIFO with valid/ready on both sides and a fill level.
// ----------------------------------------------------------------------------
module tscc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push_valid,
    output logic                         push_ready,
    input  logic [W-1:0]                 push_data,
    output logic                         pop_valid,
    input  logic                         pop_ready,
    output logic [W-1:0]                 pop_data,
    output logic [$clog2(DEPTH+1)-1:0]   level
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] level_reg, level_next;
    logic          do_push, do_pop;

    assign push_ready = (level_reg != LW'(DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/tscc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscc_front: boundary term builder
// Accepts a beat and forms the six scaled boundary terms at 2^(3F) scale.
// ----------------------------------------------------------------------------
module tscc_front #(
    parameter int FRAC_BITS = tscc_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_start_position,
    input  logic signed [31:0]    s_start_velocity,
    input  logic signed [31:0]    s_start_acceleration,
    input  logic signed [31:0]    s_end_position,
    input  logic signed [31:0]    s_end_velocity,
    input  logic signed [31:0]    s_end_acceleration,
    input  logic [30:0]           s_duration,
    output logic                  q_valid,
    input  logic                  q_ready,
    output tscc_pkg::bases_t      q_data
);
    import tscc_pkg::*;

    logic v1_reg, v2_reg, adv2;

    logic signed [31:0] sp1_reg, sa1_reg, ep1_reg, ea1_reg;
    logic [61:0]        tt1_reg;
    logic signed [63:0] tvs1_reg, tve1_reg;

    logic signed [31:0] sp2_reg, ep2_reg;
    logic signed [63:0] tvs2_reg, tve2_reg;
    logic signed [63:0] pas_lo_reg, pae_lo_reg;
    logic signed [62:0] pas_hi_reg, pae_hi_reg;

    assign adv2    = !v2_reg || q_ready;
    assign s_ready = !v1_reg || adv2;
    assign q_valid = v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            sp1_reg  <= s_start_position;
            sa1_reg  <= s_start_acceleration;
            ep1_reg  <= s_end_position;
            ea1_reg  <= s_end_acceleration;
            tt1_reg  <= 62'(s_duration) * 62'(s_duration);
            tvs1_reg <= 64'($signed({1'b0, s_duration})) * 64'(s_start_velocity);
            tve1_reg <= 64'($signed({1'b0, s_duration})) * 64'(s_end_velocity);
        end
        if (adv2) begin
            sp2_reg    <= sp1_reg;
            ep2_reg    <= ep1_reg;
            tvs2_reg   <= tvs1_reg;
            tve2_reg   <= tve1_reg;
            pas_lo_reg <= 64'(sa1_reg) * 64'($signed({1'b0, tt1_reg[31:0]}));
            pae_lo_reg <= 64'(ea1_reg) * 64'($signed({1'b0, tt1_reg[31:0]}));
            pas_hi_reg <= 63'(sa1_reg) * 63'($signed({1'b0, tt1_reg[61:32]}));
            pae_hi_reg <= 63'(ea1_reg) * 63'($signed({1'b0, tt1_reg[61:32]}));
        end
    end

    always_comb begin
        q_data.term[0] = BASE_W'(base_t'(BASE_W'(sp2_reg)) <<< (2 * FRAC_BITS));
        q_data.term[1] = BASE_W'(base_t'(BASE_W'(tvs2_reg)) <<< FRAC_BITS);
        q_data.term[2] = BASE_W'((base_t'(BASE_W'(pas_hi_reg)) <<< 32)
                                 + base_t'(BASE_W'(pas_lo_reg)));
        q_data.term[3] = BASE_W'(base_t'(BASE_W'(ep2_reg)) <<< (2 * FRAC_BITS));
        q_data.term[4] = BASE_W'(base_t'(BASE_W'(tve2_reg)) <<< FRAC_BITS);
        q_data.term[5] = BASE_W'((base_t'(BASE_W'(pae_hi_reg)) <<< 32)
                                 + base_t'(BASE_W'(pae_lo_reg)));
    end

endmodule

[rtl/tscc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscc_back: coefficient pipeline
// Issues one coefficient a cycle: weighted sum, rounding, saturation and
// division by 1944, with issue held back by free space in the result queue.
// ----------------------------------------------------------------------------
module tscc_back #(
    parameter int FRAC_BITS = tscc_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    output logic                            head_pop,
    input  tscc_pkg::bases_t                head_data,
    input  logic [tscc_pkg::OUT_LVL_W-1:0]  out_level,
    output logic                            out_push,
    output tscc_pkg::out_item_t             out_data
);
    import tscc_pkg::*;

    localparam int PD = 8;
    localparam logic signed [SUM_W-1:0] BIAS  = SUM_W'(DEN / 2) << (2 * FRAC_BITS);
    localparam logic signed [SUM_W-1:0] LIM   = SUM_W'(DEN) << SAT_EXP;
    localparam logic signed [SUM_W-1:0] NLIM  = -LIM;
    localparam logic [32:0]             RECIP = 33'd4524739209;
    localparam logic [VAL_W-1:0]        VMAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0]        VMIN  = {1'b1, {(VAL_W-1){1'b0}}};

    logic [PD-1:0]    vld_reg;
    logic [IDX_W-1:0] idx_reg [PD];
    logic [IDX_W-1:0] k_reg, k_next;
    logic             issue;
    logic [OUT_LVL_W:0] pending;

    logic signed [50:0]    p0_next [NUM_TERMS], p1_next [NUM_TERMS];
    logic signed [49:0]    p2_next [NUM_TERMS];
    logic signed [50:0]    p0_reg  [NUM_TERMS], p1_reg  [NUM_TERMS];
    logic signed [49:0]    p2_reg  [NUM_TERMS];
    logic signed [SUM_W-1:0] lane_reg [NUM_TERMS];
    logic signed [SUM_W-1:0] s01_reg, s23_reg, s45_reg, t_reg, u_reg;
    logic signed [SUM_W-1:0] tot, sh, xs;
    logic [55:0]           y_reg;
    logic [3:0]            sat_hi_reg, sat_lo_reg;
    logic [64:0]           prod1_reg, prod2_reg;
    logic [31:0]           v1_reg, qm;
    logic [23:0]           yc_reg, q1_reg, q1b_reg, q1_w;
    logic [31:0]           v2_reg;
    logic [VAL_W-1:0]      quo;

    assign pending  = {1'b0, out_level} + (OUT_LVL_W+1)'($countones(vld_reg));
    assign issue    = head_valid && (pending < (OUT_LVL_W+1)'(OUT_DEPTH));
    assign head_pop = issue && (k_reg == LAST_IDX);
    assign k_next   = issue ? ((k_reg == LAST_IDX) ? '0 : k_reg + 1'b1) : k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            k_reg   <= '0;
        end else begin
            vld_reg <= {vld_reg[PD-2:0], issue};
            k_reg   <= k_next;
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_TERMS; j++) begin
            p0_next[j] = 51'($signed({1'b0, head_data.term[j][31:0]}))
                         * 51'(coef_weight(k_reg, 3'(j)));
            p1_next[j] = 51'($signed({1'b0, head_data.term[j][63:32]}))
                         * 51'(coef_weight(k_reg, 3'(j)));
            p2_next[j] = 50'($signed(head_data.term[j][95:64]))
                         * 50'(coef_weight(k_reg, 3'(j)));
        end
    end

    assign tot = t_reg + u_reg;
    assign sh  = tot >>> (2 * FRAC_BITS);
    assign xs  = sh + LIM;
    assign q1_w = prod1_reg[63:40];
    assign qm  = 32'(q1_w) * 32'(DIV_ODD);
    assign quo = {q1b_reg, prod2_reg[63:40]};

    always_ff @(posedge aclk) begin
        idx_reg[0] <= k_reg;
        for (int i = 1; i < PD; i++) begin
            idx_reg[i] <= idx_reg[i-1];
        end
        for (int j = 0; j < NUM_TERMS; j++) begin
            p0_reg[j]   <= p0_next[j];
            p1_reg[j]   <= p1_next[j];
            p2_reg[j]   <= p2_next[j];
            lane_reg[j] <= (SUM_W'(p2_reg[j]) <<< 64) + (SUM_W'(p1_reg[j]) <<< 32)
                           + SUM_W'(p0_reg[j]);
        end
        s01_reg <= lane_reg[0] + lane_reg[1];
        s23_reg <= lane_reg[2] + lane_reg[3];
        s45_reg <= lane_reg[4] + lane_reg[5];
        t_reg   <= s01_reg + s23_reg;
        u_reg   <= s45_reg + BIAS;
        // stage 5: saturate, bias to non-negative, divide by 8
        sat_hi_reg[0] <= (sh >= LIM);
        sat_lo_reg[0] <= (sh < NLIM);
        y_reg         <= xs[58:DIV_SHIFT];
        // stages 6 to 8: two 24-bit digits of the division by 243
        prod1_reg     <= 65'(y_reg[55:24]) * 65'(RECIP);
        v1_reg        <= y_reg[55:24];
        yc_reg        <= y_reg[23:0];
        q1_reg        <= q1_w;
        v2_reg        <= {8'(v1_reg - qm), yc_reg};
        prod2_reg     <= 65'(v2_reg) * 65'(RECIP);
        q1b_reg       <= q1_reg;
        for (int i = 1; i < 4; i++) begin
            sat_hi_reg[i] <= sat_hi_reg[i-1];
            sat_lo_reg[i] <= sat_lo_reg[i-1];
        end
    end

    assign out_push      = vld_reg[PD-1];
    assign out_data.idx  = idx_reg[PD-1];
    assign out_data.last = (idx_reg[PD-1] == LAST_IDX);

    always_comb begin
        priority if (sat_hi_reg[3]) begin
            out_data.value = VMAX;
        end else if (sat_lo_reg[3]) begin
            out_data.value = VMIN;
        end else begin
            out_data.value = {~quo[VAL_W-1], quo[VAL_W-2:0]};
        end
    end

endmodule

[rtl/three_segment_cubic_coefficients.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_segment_cubic_coefficients: three-segment cubic boundary fit
// Maps start/end position, velocity, acceleration and duration to the
// twelve cubic coefficients of three equal segments, Q32.16, saturated.
//
//   channel  dir  payload                                   beats per item
//   s_       in   start/end p, v, a (Q16.16), duration      1
//   m_       out  coefficient_index, _value, is_last        12
//
// One beat in yields twelve beats out, one per cycle while m_ready is high:
// the back pipeline issues a single coefficient each cycle unless no item
// is waiting or the result queue lacks room for it.
// A two-entry queue between front and back and a 16-entry result queue
// decouple both sides; m_ready low stalls issue once queue plus pipeline fill.
// Synchronous active-low reset empties every queue and pipeline.
// ----------------------------------------------------------------------------
module three_segment_cubic_coefficients #(
    parameter int FRAC_BITS = tscc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [31:0]                     s_start_position,
    input  logic signed [31:0]                     s_start_velocity,
    input  logic signed [31:0]                     s_start_acceleration,
    input  logic signed [31:0]                     s_end_position,
    input  logic signed [31:0]                     s_end_velocity,
    input  logic signed [31:0]                     s_end_acceleration,
    input  logic [30:0]                            s_duration,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [tscc_pkg::IDX_W-1:0]             m_coefficient_index,
    output logic signed [tscc_pkg::VAL_W-1:0]      m_coefficient_value,
    output logic                                   m_is_last
);
    import tscc_pkg::*;

    logic      fq_valid, fq_ready, hd_valid, hd_pop, op_push, op_ready;
    bases_t    fq_data, hd_data;
    out_item_t op_data, om_data;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;
    logic [OUT_LVL_W-1:0]             o_level;

    tscc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_start_position, .s_start_velocity, .s_start_acceleration,
        .s_end_position, .s_end_velocity, .s_end_acceleration, .s_duration,
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    tscc_fifo #(.W($bits(bases_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn,
        .push_valid(fq_valid), .push_ready(fq_ready), .push_data(fq_data),
        .pop_valid(hd_valid), .pop_ready(hd_pop), .pop_data(hd_data),
        .level(q_level)
    );

    tscc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .head_valid(hd_valid), .head_pop(hd_pop), .head_data(hd_data),
        .out_level(o_level), .out_push(op_push), .out_data(op_data)
    );

    tscc_fifo #(.W($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_outq (
        .aclk, .aresetn,
        .push_valid(op_push), .push_ready(op_ready), .push_data(op_data),
        .pop_valid(m_valid), .pop_ready(m_ready), .pop_data(om_data),
        .level(o_level)
    );

    assign m_coefficient_index = om_data.idx;
    assign m_coefficient_value = om_data.value;
    assign m_is_last           = om_data.last;

endmodule

[rtl/tscc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscc_checker: port-level checks
// Result run order, last-beat flag, reset and stall behaviour.
// ----------------------------------------------------------------------------
module tscc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [tscc_pkg::IDX_W-1:0]         m_coefficient_index,
    input logic [tscc_pkg::VAL_W-1:0]         m_coefficient_value,
    input logic                               m_is_last
);
    import tscc_pkg::*;

    logic [IDX_W-1:0] exp_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            exp_idx_reg <= (exp_idx_reg == LAST_IDX) ? '0 : exp_idx_reg + 1'b1;
        end
    end

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_coefficient_index == exp_idx_reg)
        else $error("coefficient index out of order");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_is_last == (m_coefficient_index == LAST_IDX))
        else $error("is_last does not match index");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coefficient_value))
        else $error("stalled result beat changed");

endmodule

bind three_segment_cubic_coefficients tscc_checker u_tscc_checker (.*);
